/* design/bbrd_pkg.sv */
// bbrd_pkg: shared types and constants for the box boundary ray distance block
// payload structs, config register indexes, result codes and datapath widths
// no dependencies
package bbrd_pkg;

    localparam int COORD_W   = 32;
    localparam int DIR_W     = 18;
    localparam int FRAC_W    = 16;
    localparam int AXIS_W    = 2;
    localparam int FAULT_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_AXES  = 3;

    // divider: |offset| * 2^16 over |direction|
    localparam int NUM_W  = COORD_W + FRAC_W;
    localparam int DEN_W  = DIR_W;
    localparam int REM_W  = DIR_W - 1;
    localparam int RAT_W  = NUM_W + 1;

    // direction norm and scaling
    localparam int N2_W    = 2 * DIR_W;
    localparam int SQ_W    = N2_W + FRAC_W;
    localparam int NORM_W  = SQ_W / 2;
    localparam int HALF_W  = NUM_W / 2;
    localparam int PP_W    = HALF_W + NORM_W;
    localparam int PROD_W  = NUM_W + NORM_W;
    localparam int SCALE_W = 24;

    localparam logic signed [DIR_W-1:0] DIR_X_RESET = 18'sd65536;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [FAULT_W-1:0] FAULT_OK       = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_ZERO_DIR = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_SAT      = 2'd2;

    localparam logic signed [COORD_W-1:0] DIST_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] DIST_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIR_X   = 3'd0,
        REG_DIR_Y   = 3'd1,
        REG_DIR_Z   = 3'd2,
        REG_LOWER_X = 3'd3,
        REG_LOWER_Y = 3'd4,
        REG_LOWER_Z = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } bbrd_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] distance;
        logic [AXIS_W-1:0]         min_axis;
        logic [FAULT_W-1:0]        fault;
    } bbrd_out_t;

endpackage

/* design/bbrd_div.sv */
// bbrd_div: pipelined restoring divider, one quotient bit per stage
// depends on bbrd_pkg for widths
module bbrd_div (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [bbrd_pkg::NUM_W-1:0] num,
    input  logic [bbrd_pkg::DEN_W-1:0] den,
    input  logic                       neg,
    output logic [bbrd_pkg::NUM_W-1:0] quot,
    output logic                       quot_neg
);
    import bbrd_pkg::*;

    logic [REM_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [NUM_W-1:0] q_reg   [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic             neg_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [REM_W-1:0] rem_cur;
        logic [NUM_W-1:0] num_cur;
        logic [NUM_W-1:0] q_cur;
        logic [DEN_W-1:0] den_cur;
        logic             neg_cur;
        logic [DEN_W-1:0] trial;
        logic [DEN_W-1:0] diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_cur = '0;
            assign num_cur = num;
            assign q_cur   = '0;
            assign den_cur = den;
            assign neg_cur = neg;
        end else begin : g_next
            assign rem_cur = rem_reg[k-1];
            assign num_cur = num_reg[k-1];
            assign q_cur   = q_reg[k-1];
            assign den_cur = den_reg[k-1];
            assign neg_cur = neg_reg[k-1];
        end

        assign trial = {rem_cur, num_cur[NUM_W-1]};
        assign diff  = trial - den_cur;
        assign ge    = (trial >= den_cur);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                num_reg[k] <= {num_cur[NUM_W-2:0], 1'b0};
                q_reg[k]   <= {q_cur[NUM_W-2:0], ge};
                den_reg[k] <= den_cur;
                neg_reg[k] <= neg_cur;
            end
        end
    end

    assign quot     = q_reg[NUM_W-1];
    assign quot_neg = neg_reg[NUM_W-1];

endmodule

/* design/box_boundary_ray_distance.sv */
// box_boundary_ray_distance: point to lower box face distance along a fixed direction
// throughput: one request per cycle, while s_ready is high, through the 48-stage
// per-axis divider pipelines; the direction norm comes from a bit-pair square root
// that runs after reset and after every direction write; s_ready stays low while it runs
// reset: aresetn synchronous, active low; clears valid bits, config and the norm state
module box_boundary_ray_distance #(
    parameter int DIMENSIONS = 3
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bbrd_pkg::bbrd_in_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bbrd_pkg::bbrd_out_t            m_data,
    input  logic                           cfg_we,
    input  logic [bbrd_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [bbrd_pkg::COORD_W-1:0]   cfg_wdata
);
    import bbrd_pkg::*;

    // clamp the dimension count into 1..3
    localparam int NDIM  = (DIMENSIONS < 1) ? 1 : ((DIMENSIONS > 3) ? 3 : DIMENSIONS);
    // input reg, prep reg, divider stages, ratio, min, product
    localparam int DEPTH = NUM_W + 5;

    typedef enum logic [2:0] {
        SQ_LOAD = 3'b001,
        SQ_RUN  = 3'b010,
        SQ_IDLE = 3'b100
    } sq_state_t;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic signed [DIR_W-1:0]   dir_x_reg, dir_y_reg, dir_z_reg;
    logic signed [COORD_W-1:0] lower_x_reg, lower_y_reg, lower_z_reg;
    logic                      dir_write;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_x_reg   <= DIR_X_RESET;
            dir_y_reg   <= '0;
            dir_z_reg   <= '0;
            lower_x_reg <= '0;
            lower_y_reg <= '0;
            lower_z_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_DIR_X:   dir_x_reg   <= cfg_wdata[DIR_W-1:0];
                REG_DIR_Y:   dir_y_reg   <= cfg_wdata[DIR_W-1:0];
                REG_DIR_Z:   dir_z_reg   <= cfg_wdata[DIR_W-1:0];
                REG_LOWER_X: lower_x_reg <= cfg_wdata;
                REG_LOWER_Y: lower_y_reg <= cfg_wdata;
                REG_LOWER_Z: lower_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // any direction write invalidates the norm
    assign dir_write = cfg_we && (cfg_idx == REG_DIR_X || cfg_idx == REG_DIR_Y ||
                                  cfg_idx == REG_DIR_Z);

    // ---------------------------------------------------------------
    // direction norm: |w| in Q.24 = isqrt(sum w^2 << 16), two bits per cycle
    // ---------------------------------------------------------------
    sq_state_t            sq_state_reg, sq_state_next;
    logic [SQ_W-1:0]      sq_v_reg, sq_v_next;
    logic [SQ_W-1:0]      sq_res_reg, sq_res_next;
    logic [SQ_W-1:0]      sq_bit_reg, sq_bit_next;
    logic [NORM_W-1:0]    nrm_reg, nrm_next;
    logic signed [N2_W-1:0] sqx, sqy, sqz;
    logic [N2_W-1:0]      n2;
    logic [SQ_W-1:0]      sq_trial;

    assign sqx      = dir_x_reg * dir_x_reg;
    assign sqy      = dir_y_reg * dir_y_reg;
    assign sqz      = dir_z_reg * dir_z_reg;
    assign n2       = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
    assign sq_trial = sq_res_reg + sq_bit_reg;

    always_comb begin
        sq_state_next = sq_state_reg;
        sq_v_next     = sq_v_reg;
        sq_res_next   = sq_res_reg;
        sq_bit_next   = sq_bit_reg;
        nrm_next      = nrm_reg;
        case (sq_state_reg)
            SQ_LOAD: begin
                sq_v_next     = {n2, {FRAC_W{1'b0}}};
                sq_res_next   = '0;
                // highest power of four below 2^SQ_W
                sq_bit_next   = {2'b01, {(SQ_W-2){1'b0}}};
                sq_state_next = SQ_RUN;
            end
            SQ_RUN: begin
                if (sq_v_reg >= sq_trial) begin
                    sq_v_next   = sq_v_reg - sq_trial;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg[0]) begin
                    nrm_next      = sq_res_next[NORM_W-1:0];
                    sq_state_next = SQ_IDLE;
                end
            end
            SQ_IDLE: ;
            default: sq_state_next = SQ_LOAD;
        endcase
        if (dir_write) begin
            sq_state_next = SQ_LOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_state_reg <= SQ_LOAD;
        end else begin
            sq_state_reg <= sq_state_next;
        end
        sq_v_reg   <= sq_v_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        nrm_reg    <= nrm_next;
    end

    // ---------------------------------------------------------------
    // pipeline control: everything advances unless the skid slot is full
    // ---------------------------------------------------------------
    logic             en;
    logic [DEPTH-1:0] vld_reg;
    logic             skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en && (sq_state_reg == SQ_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid && s_ready};
        end
    end

    // stage 0: request register
    bbrd_in_t in_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_data;
        end
    end

    // per-axis views of point, bound and direction
    logic signed [COORD_W-1:0] pt [NUM_AXES];
    logic signed [COORD_W-1:0] lo [NUM_AXES];
    logic signed [DIR_W-1:0]   w  [NUM_AXES];

    assign pt[0] = in_reg.point_x;
    assign pt[1] = in_reg.point_y;
    assign pt[2] = in_reg.point_z;
    assign lo[0] = lower_x_reg;
    assign lo[1] = lower_y_reg;
    assign lo[2] = lower_z_reg;
    assign w[0]  = dir_x_reg;
    assign w[1]  = dir_y_reg;
    assign w[2]  = dir_z_reg;

    // stage 1: magnitudes for the divider, stages 2..: divider, then signed ratio
    logic [NUM_W-1:0]        num_reg [NUM_AXES];
    logic [DEN_W-1:0]        den_reg [NUM_AXES];
    logic                    neg_reg [NUM_AXES];
    logic [NUM_W-1:0]        quot    [NUM_AXES];
    logic                    quot_neg[NUM_AXES];
    logic signed [RAT_W-1:0] r_reg   [NUM_AXES];

    for (genvar d = 0; d < NUM_AXES; d++) begin : g_axis
        logic signed [COORD_W:0] off;
        logic [COORD_W:0]        off_abs;
        logic [DIR_W-1:0]        w_abs;
        logic signed [RAT_W-1:0] q_pos;

        assign off     = (COORD_W+1)'(pt[d]) - (COORD_W+1)'(lo[d]);
        assign off_abs = off[COORD_W] ? (COORD_W+1)'(-off) : (COORD_W+1)'(off);
        assign w_abs   = w[d][DIR_W-1] ? DIR_W'(-w[d]) : DIR_W'(w[d]);

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[d] <= {off_abs[COORD_W-1:0], {FRAC_W{1'b0}}};
                den_reg[d] <= w_abs;
                neg_reg[d] <= off[COORD_W] ^ w[d][DIR_W-1];
            end
        end

        bbrd_div u_div (
            .aclk     (aclk),
            .en       (en),
            .num      (num_reg[d]),
            .den      (den_reg[d]),
            .neg      (neg_reg[d]),
            .quot     (quot[d]),
            .quot_neg (quot_neg[d])
        );

        // quotient truncates toward zero, so the sign goes on the magnitude
        assign q_pos = signed'({1'b0, quot[d]});

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[d] <= quot_neg[d] ? -q_pos : q_pos;
            end
        end
    end

    // min stage: smallest ratio, earlier axis wins a tie
    logic signed [RAT_W-1:0] rmin_reg, rmin_next;
    logic [AXIS_W-1:0]       axis_reg, axis_next;

    always_comb begin
        rmin_next = r_reg[0];
        axis_next = AXIS_X;
        if (NDIM >= 2 && r_reg[1] < rmin_next) begin
            rmin_next = r_reg[1];
            axis_next = AXIS_Y;
        end
        if (NDIM >= 3 && r_reg[2] < rmin_next) begin
            rmin_next = r_reg[2];
            axis_next = AXIS_Z;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rmin_reg <= rmin_next;
            axis_reg <= axis_next;
        end
    end

    // product stage: |r| times the norm as two half-width partial products
    logic [RAT_W-1:0]        a_full;
    logic [NUM_W-1:0]        a_abs;
    logic [NUM_W-1:0]        a_p_reg;
    logic signed [RAT_W-1:0] rmin_p_reg;
    logic [AXIS_W-1:0]       axis_p_reg;
    logic [PP_W-1:0]         pp_hi_reg, pp_lo_reg;

    assign a_full = rmin_reg[RAT_W-1] ? RAT_W'(-rmin_reg) : RAT_W'(rmin_reg);
    assign a_abs  = a_full[NUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            a_p_reg    <= a_abs;
            rmin_p_reg <= rmin_reg;
            axis_p_reg <= axis_reg;
            pp_hi_reg  <= PP_W'(a_abs[NUM_W-1:HALF_W]) * PP_W'(nrm_reg);
            pp_lo_reg  <= PP_W'(a_abs[HALF_W-1:0]) * PP_W'(nrm_reg);
        end
    end

    // final stage: combine, scale, saturate, flag zero direction
    logic [PROD_W-1:0]  prod;
    logic               zero_dir;
    logic               sat;
    logic signed [COORD_W-1:0] dist_val;
    bbrd_out_t          pipe_out;

    assign prod = {pp_hi_reg, {HALF_W{1'b0}}} + PROD_W'(pp_lo_reg);

    assign zero_dir = (dir_x_reg == '0) ||
                      (NDIM >= 2 && dir_y_reg == '0) ||
                      (NDIM >= 3 && dir_z_reg == '0);

    always_comb begin
        sat      = 1'b0;
        dist_val = '0;
        if (NDIM == 1) begin
            // signed ratio, both ends can clip
            sat = (rmin_p_reg[RAT_W-1:COORD_W-1] != '0) &&
                  (rmin_p_reg[RAT_W-1:COORD_W-1] != '1);
            if (sat) begin
                dist_val = rmin_p_reg[RAT_W-1] ? DIST_MIN : DIST_MAX;
            end else begin
                dist_val = rmin_p_reg[COORD_W-1:0];
            end
        end else if (NDIM == 2) begin
            // two axes: the distance is |r| itself, not scaled by the norm, clipped at the top rail
            sat      = (a_p_reg[NUM_W-1:COORD_W-1] != '0);
            dist_val = sat ? DIST_MAX : signed'({1'b0, a_p_reg[COORD_W-2:0]});
        end else begin
            sat      = (prod[PROD_W-1:SCALE_W+COORD_W-1] != '0);
            dist_val = sat ? DIST_MAX : signed'({1'b0, prod[SCALE_W+COORD_W-2:SCALE_W]});
        end

        if (zero_dir) begin
            pipe_out.distance = '0;
            pipe_out.min_axis = AXIS_X;
            pipe_out.fault    = FAULT_ZERO_DIR;
        end else begin
            pipe_out.distance = dist_val;
            pipe_out.min_axis = axis_p_reg;
            pipe_out.fault    = sat ? FAULT_SAT : FAULT_OK;
        end
    end

    // ---------------------------------------------------------------
    // output register plus skid slot: the pipe keeps moving for one
    // result while m_ready is low, then stalls
    // ---------------------------------------------------------------
    logic      out_valid_reg;
    bbrd_out_t out_data_reg;
    bbrd_out_t skid_data_reg;
    logic      pipe_valid;
    logic      take;

    assign pipe_valid = vld_reg[DEPTH-1] && en;
    assign take       = m_ready || !out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= pipe_valid;
            end
        end else if (pipe_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : pipe_out;
        end else if (pipe_valid) begin
            skid_data_reg <= pipe_out;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* design/bbrd_chk.sv */
// bbrd_chk: port-level checks for box_boundary_ray_distance, bound to the top level
// depends on bbrd_pkg for payload types and result codes
module bbrd_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input bbrd_pkg::bbrd_out_t            m_data
);
    import bbrd_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing comes out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // zero direction gives a clean zero result
    a_zero_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.fault == FAULT_ZERO_DIR |->
            m_data.distance == '0 && m_data.min_axis == AXIS_X)
        else $error("zero direction result not cleared");

    // saturation only at the rails
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.fault == FAULT_SAT |->
            m_data.distance == DIST_MAX || m_data.distance == DIST_MIN)
        else $error("saturated result off the rails");

endmodule

bind box_boundary_ray_distance bbrd_chk u_bbrd_chk (.*);
